// ----- rtl/mmgn_pkg.sv -----
// mmgn_pkg: shared types, widths and codes of the min-max gray normalizer
// used by mmgn_store, mmgn_div and min_max_gray_normalizer
package mmgn_pkg;

    localparam int SAMPLE_BITS  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int GRAY_BITS    = 8;
    localparam int MAX_SIDE_DEF = 64;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    // stretch division: (2*255*d + span) / (2*span)
    localparam int NUM_BITS   = SAMPLE_BITS + 8;
    localparam int DVD_BITS   = SAMPLE_BITS + 10;
    localparam int DVS_BITS   = SAMPLE_BITS + 1;
    localparam int QUOT_BITS  = GRAY_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(DVD_BITS + 1);

    localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_RST   = ~SIGN_MASK;
    localparam logic [SAMPLE_BITS-1:0] MAX_RST   = SIGN_MASK;
    localparam logic [SAMPLE_BITS:0]   ROUND_HALF =
        (SAMPLE_BITS+1)'(1) << (FRAC_BITS - 1);
    localparam logic [GRAY_BITS-1:0]   GRAY_MAX  = '1;

    localparam logic [CFG_DATA_W-1:0] SIDE_RST = CFG_DATA_W'(64);

    localparam logic [CFG_ADDR_W-1:0] CFG_NORM_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/mmgn_store.sv -----
// mmgn_store: single-port-write, registered-read sample memory
// depends on mmgn_pkg for the sample width
module mmgn_store import mmgn_pkg::*; #(
    parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
    parameter int AW    = $clog2(MAX_SIDE_DEF * MAX_SIDE_DEF)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [0:DEPTH-1];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mmgn_div.sv -----
// mmgn_div: bit-serial restoring divider, one quotient bit per cycle
// computes (2*num + span) / (2*span); depends on mmgn_pkg
module mmgn_div import mmgn_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUM_BITS-1:0]    i_num,
    input  logic [SAMPLE_BITS-1:0] i_span,
    output t_div_stat              o_stat,
    output logic [QUOT_BITS-1:0]   o_quot
);

    logic [DVD_BITS-1:0]  r_dvd;
    logic [DVS_BITS-1:0]  r_dvs;
    logic [DVS_BITS-1:0]  r_rem;
    logic [QUOT_BITS-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVS_BITS:0]    trial;
    logic [DVS_BITS:0]    diff;
    logic                 fits;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= (DVD_BITS'(i_num) << 1) + DVD_BITS'(i_span);
            r_dvs  <= {i_span, 1'b0};
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= r_dvd << 1;
            r_rem  <= fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            r_quot <= {r_quot[QUOT_BITS-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ----- rtl/min_max_gray_normalizer.sv -----
// min_max_gray_normalizer: top level, frame load, min/max tracking and read sequencing
// depends on mmgn_pkg, mmgn_store and mmgn_div
//
// input channel (s_axis): tuser = command, tdata = signed Q16.16 sample.
// a load command stores one sample of the frame (height samples per output
// column) and updates the running min and max.
// loads past a full frame are dropped without a result.
// a read command returns one gray pixel on m_axis in raster order of the
// rotated frame (row r, column c is stored sample c*height+height-1-r):
// tdata = gray, tuser = frame ready, tlast = last pixel. a read before the
// frame is full answers gray 0 with frame ready low, going straight to the done state.
// in fixed mode a read passes the address, clamp and done states; stretch
// mode adds the diff state and, when max is above min, the multiply, start
// and divide states, the bit-serial divider producing one quotient bit per
// cycle over the 42-bit dividend. one read is in flight at a time; loads,
// one per cycle, and reads are taken only while idle. s_axis_tready is high
// while the sequencer is idle, even while a finished pixel waits in the
// output register. if m_axis stalls, the next pixel waits in the sequencer
// and no further item is taken.
// after the last pixel, or a write of image width or height, the block
// restarts with an empty frame. reset gives stretch mode, 64 x 64 frame.
module min_max_gray_normalizer import mmgn_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] sample
    input  logic [0:0]            s_axis_tuser,   // [0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] gray
    output logic [0:0]            m_axis_tuser,   // [0] frame_ready
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CAP   = (MAX_SIDE < 127) ? MAX_SIDE : 127;
    localparam int DEPTH = CAP * CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RCW   = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [CFG_DATA_W-1:0] SIDE_CAP = CFG_DATA_W'(CAP);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADDR  = 8'b0000_0010,
        S_CLAMP = 8'b0000_0100,
        S_DIFF  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_START = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;

    logic                    r_mode;
    logic [CFG_DATA_W-1:0]   r_width;
    logic [CFG_DATA_W-1:0]   r_height;
    logic [SAMPLE_BITS-1:0]  r_min;
    logic [SAMPLE_BITS-1:0]  r_max;
    logic [CW-1:0]           r_count;
    logic [RCW-1:0]          r_row;
    logic [RCW-1:0]          r_col;

    logic [AW-1:0]           r_addr;
    logic                    r_last_rd;
    logic                    r_rd_ok;
    logic [SAMPLE_BITS-1:0]  r_bs;
    logic [SAMPLE_BITS-1:0]  r_span;
    logic                    r_zero;
    logic [SAMPLE_BITS-1:0]  r_diff;
    logic [NUM_BITS-1:0]     r_num;
    logic [GRAY_BITS-1:0]    r_gray;

    logic                    r_out_valid;
    logic [GRAY_BITS-1:0]    r_out_gray;
    logic                    r_out_ready;
    logic                    r_out_last;

    logic [CFG_DATA_W-1:0]   w_eff;
    logic [CFG_DATA_W-1:0]   h_eff;
    logic [CW-1:0]           total;
    logic                    full;
    logic                    in_acc;
    logic                    is_read;
    logic                    load_wr;
    logic [CW-1:0]           rd_idx;
    logic [7:0]              col_p1;
    logic [7:0]              row_p1;
    logic                    col_wrap;
    logic                    frame_end;
    logic                    out_free;
    logic                    advance;
    logic                    do_restart;

    logic [SAMPLE_BITS-1:0]  rdata;
    logic [SAMPLE_BITS-1:0]  lo;
    logic [SAMPLE_BITS-1:0]  hi;
    logic [SAMPLE_BITS-1:0]  bs;
    logic [SAMPLE_BITS-1:0]  bs_c;
    logic [SAMPLE_BITS:0]    fix_sum;
    logic [SAMPLE_BITS-FRAC_BITS:0] fix_val;
    logic [GRAY_BITS-1:0]    fix_gray;

    t_div_stat               div_stat;
    logic [QUOT_BITS-1:0]    div_quot;

    // effective frame size
    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_DATA_W'(1);
        end else if (r_width > SIDE_CAP) begin
            w_eff = SIDE_CAP;
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = CFG_DATA_W'(1);
        end else if (r_height > SIDE_CAP) begin
            h_eff = SIDE_CAP;
        end else begin
            h_eff = r_height;
        end
    end

    always_comb begin
        total     = CW'(CW'(w_eff) * CW'(h_eff));
        full      = !(r_count < total);
        in_acc    = s_axis_tvalid && s_axis_tready;
        is_read   = s_axis_tuser[0] == CMD_READ;
        load_wr   = in_acc && !is_read && !full;
        rd_idx    = CW'(CW'(r_col) * CW'(h_eff)) + CW'(h_eff) - CW'(1) - CW'(r_row);
        col_p1    = 8'(r_col) + 8'd1;
        row_p1    = 8'(r_row) + 8'd1;
        col_wrap  = col_p1 >= {1'b0, w_eff};
        frame_end = col_wrap && (row_p1 >= {1'b0, h_eff});
        out_free  = !r_out_valid || m_axis_tready;
        advance   = (r_state == S_DONE) && out_free && r_rd_ok;
        do_restart = (advance && r_last_rd) ||
                     (i_cfg_we && ((i_cfg_addr == CFG_IMAGE_WIDTH) ||
                                   (i_cfg_addr == CFG_IMAGE_HEIGHT)));
    end

    // pixel datapath
    always_comb begin
        lo       = r_min ^ SIGN_MASK;
        hi       = r_max ^ SIGN_MASK;
        bs       = rdata ^ SIGN_MASK;
        if (bs < lo) begin
            bs_c = lo;
        end else if (bs > hi) begin
            bs_c = hi;
        end else begin
            bs_c = bs;
        end
        fix_sum  = {1'b0, rdata} + ROUND_HALF;
        fix_val  = fix_sum[SAMPLE_BITS:FRAC_BITS];
        if (rdata[SAMPLE_BITS-1]) begin
            fix_gray = '0;
        end else if ((fix_val >> GRAY_BITS) != '0) begin
            fix_gray = GRAY_MAX;
        end else begin
            fix_gray = fix_val[GRAY_BITS-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_read) begin
                    n_state = full ? S_ADDR : S_DONE;
                end
            end
            S_ADDR:  n_state = S_CLAMP;
            S_CLAMP: n_state = r_mode ? S_DIFF : S_DONE;
            S_DIFF:  n_state = r_zero ? S_DONE : S_MUL;
            S_MUL:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b1;
            r_width     <= SIDE_RST;
            r_height    <= SIDE_RST;
            r_min       <= MIN_RST;
            r_max       <= MAX_RST;
            r_count     <= '0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (do_restart) begin
                r_min   <= MIN_RST;
                r_max   <= MAX_RST;
                r_count <= '0;
                r_row   <= '0;
                r_col   <= '0;
            end else begin
                if (load_wr) begin
                    r_count <= r_count + CW'(1);
                    if ($signed(s_axis_tdata) < $signed(r_min)) begin
                        r_min <= s_axis_tdata;
                    end
                    if ($signed(s_axis_tdata) > $signed(r_max)) begin
                        r_max <= s_axis_tdata;
                    end
                end
                if (advance) begin
                    if (col_wrap) begin
                        r_col <= '0;
                        r_row <= RCW'(row_p1);
                    end else begin
                        r_col <= RCW'(col_p1);
                    end
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NORM_MODE:    r_mode   <= i_cfg_data[0];
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_acc && is_read) begin
            r_addr    <= rd_idx[AW-1:0];
            r_rd_ok   <= full;
            r_last_rd <= full && frame_end;
            r_gray    <= '0;
        end
        if (r_state == S_CLAMP) begin
            r_bs   <= bs_c;
            r_span <= hi - lo;
            r_zero <= hi <= lo;
            if (!r_mode) begin
                r_gray <= fix_gray;
            end
        end
        if (r_state == S_DIFF) begin
            r_diff <= r_bs - lo;
        end
        if (r_state == S_MUL) begin
            r_num <= (NUM_BITS'(r_diff) << GRAY_BITS) - NUM_BITS'(r_diff);
        end
        if ((r_state == S_DIV) && div_stat.done) begin
            r_gray <= div_quot[QUOT_BITS-1] ? GRAY_MAX : div_quot[GRAY_BITS-1:0];
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_gray  <= r_gray;
            r_out_ready <= r_rd_ok;
            r_out_last  <= r_last_rd;
        end
    end

    mmgn_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (r_state == S_ADDR),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    mmgn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_num   (r_num),
        .i_span  (r_span),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign s_axis_tready   = r_state == S_IDLE;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_gray;
    assign m_axis_tuser[0] = r_out_ready;
    assign m_axis_tlast    = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= total)
        else $error("load count beyond frame size");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("last pixel flagged on a not-ready frame");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last_rd) |=> ((r_count == '0) && (r_row == '0) && (r_col == '0)))
        else $error("frame did not restart after last pixel");
`endif

endmodule
